>>> rtl/core/dasf_pkg.sv
// Shared types, codes and constants for the drowsiness alert session unit.
// Depends on nothing; every other file imports it.
package dasf_pkg;

    localparam int SCORE_BITS_DEF = 16;
    localparam int FIELD_W        = 16;
    localparam int HOLD_W         = 32;
    localparam int STATE_W        = 3;
    localparam int REQ_W          = 2;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    localparam logic [STATE_W-1:0] ST_IDLE     = 3'd0;
    localparam logic [STATE_W-1:0] ST_WARMUP   = 3'd1;
    localparam logic [STATE_W-1:0] ST_BASELINE = 3'd2;
    localparam logic [STATE_W-1:0] ST_SUSPECT  = 3'd3;
    localparam logic [STATE_W-1:0] ST_ALERTING = 3'd4;
    localparam logic [STATE_W-1:0] ST_COOLDOWN = 3'd5;
    localparam logic [STATE_W-1:0] ST_CLOSING  = 3'd6;
    localparam logic [STATE_W-1:0] ST_INVALID  = 3'd7;

    localparam logic [REQ_W-1:0] REQ_TICK     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RESTART  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FORCE    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_FORCE   = 2'd2;
    localparam logic [1:0] CMD_NOP     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SUSPECT_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALERT_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEART_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSPECT_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_MS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_MS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MS = 3'd6;

    localparam logic [FIELD_W-1:0] DEF_SUSPECT_THR = 16'd32768;
    localparam logic [FIELD_W-1:0] DEF_ALERT_THR   = 16'd45875;
    localparam logic [FIELD_W-1:0] DEF_HEART_THR   = 16'd32768;
    localparam logic [HOLD_W-1:0]  DEF_SUSPECT_MS  = 32'd2000;
    localparam logic [HOLD_W-1:0]  DEF_FAST_MS     = 32'd1000;
    localparam logic [HOLD_W-1:0]  DEF_SLOW_MS     = 32'd5000;
    localparam logic [HOLD_W-1:0]  DEF_COOLDOWN_MS = 32'd10000;

    typedef struct packed {
        logic [FIELD_W-1:0] t1;
        logic [FIELD_W-1:0] t2;
        logic [FIELD_W-1:0] h1;
    } t_thresh;

    typedef struct packed {
        logic [HOLD_W-1:0] suspect;
        logic [HOLD_W-1:0] fast;
        logic [HOLD_W-1:0] slow;
        logic [HOLD_W-1:0] cooldown;
    } t_holds;

    typedef struct packed {
        logic [1:0]         kind;
        logic               ge_t1;
        logic               ge_t2;
        logic               hr_ok;
        logic [FIELD_W-1:0] score;
        logic [FIELD_W-1:0] dt;
        logic [STATE_W-1:0] forced;
    } t_cmd;

    function automatic logic [HOLD_W-1:0] sat_add(input logic [HOLD_W-1:0] a,
                                                  input logic [FIELD_W-1:0] b);
        logic [HOLD_W:0] s;
        s = {1'b0, a} + {{(HOLD_W+1-FIELD_W){1'b0}}, b};
        return s[HOLD_W] ? {HOLD_W{1'b1}} : s[HOLD_W-1:0];
    endfunction

endpackage

>>> rtl/core/dasf_ifs.sv
// Channel interfaces: request, result and configuration write.
// Depends on dasf_pkg for field widths.
interface dasf_in_if import dasf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [FIELD_W-1:0] fused_score;
    logic [FIELD_W-1:0] heart_weight;
    logic [FIELD_W-1:0] elapsed_ms;
    logic [STATE_W-1:0] forced_state;

    modport source (output valid, req_type, fused_score, heart_weight, elapsed_ms,
                    forced_state, input ready);
    modport sink   (input valid, req_type, fused_score, heart_weight, elapsed_ms,
                    forced_state, output ready);
endinterface

interface dasf_out_if import dasf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] session_state;
    logic [FIELD_W-1:0] peak_score;

    modport source (output valid, session_state, peak_score, input ready);
    modport sink   (input valid, session_state, peak_score, output ready);
endinterface

interface dasf_cfg_if import dasf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/dasf_front.sv
// Front end: accepts requests and classifies them into queue commands,
// doing the threshold compares up front. Depends on dasf_pkg.
module dasf_front import dasf_pkg::*; #(
    parameter int SCORE_BITS = SCORE_BITS_DEF
) (
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [FIELD_W-1:0] i_fused_score,
    input  logic [FIELD_W-1:0] i_heart_weight,
    input  logic [FIELD_W-1:0] i_elapsed_ms,
    input  logic [STATE_W-1:0] i_forced_state,
    input  t_thresh            i_thresh,
    output logic               o_push,
    output t_cmd               o_cmd,
    input  logic               i_push_ready
);

    localparam logic [FIELD_W-1:0] MASK =
        (SCORE_BITS >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((64'd1 << SCORE_BITS) - 64'd1);

    logic [FIELD_W-1:0] score_m;
    logic [FIELD_W-1:0] heart_m;

    assign score_m = i_fused_score & MASK;
    assign heart_m = i_heart_weight & MASK;

    assign o_ready = i_push_ready;
    assign o_push  = i_valid;

    always_comb begin
        o_cmd.ge_t1  = score_m >= (i_thresh.t1 & MASK);
        o_cmd.ge_t2  = score_m >= (i_thresh.t2 & MASK);
        o_cmd.hr_ok  = heart_m >= (i_thresh.h1 & MASK);
        o_cmd.score  = score_m;
        o_cmd.dt     = i_elapsed_ms;
        o_cmd.forced = i_forced_state;
        case (i_req_type)
            REQ_TICK:    o_cmd.kind = CMD_TICK;
            REQ_RESTART: o_cmd.kind = CMD_RESTART;
            REQ_FORCE:   o_cmd.kind = (i_forced_state == ST_INVALID) ? CMD_NOP : CMD_FORCE;
            default:     o_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

>>> rtl/core/dasf_queue.sv
// Short command queue between front and back end.
// Depends on dasf_pkg for the command type and depth.
module dasf_queue import dasf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_push_ready = r_cnt != CNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_cmd        = r_slot[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == LAST) ? '0 : r_wr + PTR_W'(1);
            if (do_pop)  r_rd <= (r_rd == LAST) ? '0 : r_rd + PTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wr] <= i_cmd;
    end

endmodule

>>> rtl/core/dasf_back.sv
// Back end: session state machine, hold accumulators, peak tracker and
// the result register. Depends on dasf_pkg.
module dasf_back import dasf_pkg::*; #(
    parameter int SCORE_BITS = SCORE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    input  t_holds             i_holds,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [STATE_W-1:0] o_session_state,
    output logic [FIELD_W-1:0] o_peak_score
);

    localparam int PEAK_W = (SCORE_BITS < FIELD_W) ? SCORE_BITS : FIELD_W;

    logic [STATE_W-1:0] r_mode, n_mode;
    logic [HOLD_W-1:0]  r_sacc, n_sacc, r_aacc, n_aacc, r_cacc, n_cacc;
    logic [HOLD_W-1:0]  s_sum, a_sum, c_sum;
    logic [PEAK_W-1:0]  r_peak, n_peak;
    logic               r_ovld;

    assign o_pop           = i_cmd_valid && (!r_ovld || i_ready);
    assign o_valid         = r_ovld;
    assign o_session_state = r_mode;
    assign o_peak_score    = FIELD_W'(r_peak);

    assign s_sum = sat_add(r_sacc, i_cmd.dt);
    assign a_sum = sat_add(r_aacc, i_cmd.dt);
    assign c_sum = sat_add(r_cacc, i_cmd.dt);

    always_comb begin
        n_mode = r_mode;
        n_sacc = r_sacc;
        n_aacc = r_aacc;
        n_cacc = r_cacc;
        n_peak = r_peak;
        case (i_cmd.kind)
            CMD_TICK: begin
                case (r_mode)
                    ST_BASELINE: begin
                        if (i_cmd.ge_t2) begin
                            n_aacc = a_sum;
                            n_sacc = s_sum;
                        end else if (i_cmd.ge_t1) begin
                            n_sacc = s_sum;
                            n_aacc = '0;
                        end else begin
                            n_sacc = '0;
                            n_aacc = '0;
                        end
                        if (n_sacc >= i_holds.suspect) n_mode = ST_SUSPECT;
                    end
                    ST_SUSPECT: begin
                        if (i_cmd.ge_t2) begin
                            n_aacc = a_sum;
                            if (a_sum >= i_holds.fast) n_mode = ST_ALERTING;
                        end else if (i_cmd.ge_t1) begin
                            n_aacc = '0;
                            n_sacc = s_sum;
                            if (s_sum >= i_holds.slow && i_cmd.hr_ok) n_mode = ST_ALERTING;
                        end else begin
                            n_mode = ST_BASELINE;
                            n_sacc = '0;
                            n_aacc = '0;
                        end
                    end
                    ST_COOLDOWN: begin
                        if (!i_cmd.ge_t1) begin
                            n_cacc = c_sum;
                            if (c_sum >= i_holds.cooldown) begin
                                n_mode = ST_BASELINE;
                                n_sacc = '0;
                                n_aacc = '0;
                                n_cacc = '0;
                            end
                        end else begin
                            n_cacc = '0;
                            if (i_cmd.ge_t2) n_mode = ST_ALERTING;
                        end
                    end
                    default: n_mode = r_mode;
                endcase
                // score is already masked, so its upper bits are zero here
                if (i_cmd.score[PEAK_W-1:0] > r_peak) n_peak = i_cmd.score[PEAK_W-1:0];
            end
            CMD_RESTART: begin
                n_mode = ST_BASELINE;
                n_sacc = '0;
                n_aacc = '0;
                n_cacc = '0;
                n_peak = '0;
            end
            CMD_FORCE: n_mode = i_cmd.forced;
            default:   n_mode = r_mode;
        endcase
    end

    // state only moves on a pop, so it doubles as the held result payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ST_IDLE;
            r_sacc <= '0;
            r_aacc <= '0;
            r_cacc <= '0;
            r_peak <= '0;
            r_ovld <= 1'b0;
        end else if (o_pop) begin
            r_mode <= n_mode;
            r_sacc <= n_sacc;
            r_aacc <= n_aacc;
            r_cacc <= n_cacc;
            r_peak <= n_peak;
            r_ovld <= 1'b1;
        end else if (i_ready) begin
            r_ovld <= 1'b0;
        end
    end

endmodule

>>> rtl/core/drowsiness_alert_session_fsm_unit.sv
// Top level of the drowsiness alert session unit: configuration registers,
// front end, command queue and back end. Depends on dasf_pkg and dasf_ifs.
//
//  channel  | dir | handshake     | payload
//  i_req    | in  | valid / ready | req_type, fused_score, heart_weight,
//           |     |               | elapsed_ms, forced_state
//  o_res    | out | valid / ready | session_state, peak_score
//  i_cfg    | in  | valid / ready | index, data (ready is always high)
//
// Sustained rate is one request per cycle while results are taken. An
// accepted request goes into the queue, then the back end updates its
// result register (saturating add and hold compare). Reset enters idle
// with zero accumulators and peak and loads default thresholds and holds.
// A stalled result holds in its register while the two-entry queue fills.
module drowsiness_alert_session_fsm_unit import dasf_pkg::*; #(
    parameter int SCORE_BITS = SCORE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dasf_in_if.sink           i_req,
    dasf_out_if.source        o_res,
    dasf_cfg_if.sink          i_cfg
);

    t_thresh r_thresh;
    t_holds  r_holds;
    t_cmd    front_cmd, queue_cmd;
    logic    front_push, queue_ready, queue_valid, back_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.t1      <= DEF_SUSPECT_THR;
            r_thresh.t2      <= DEF_ALERT_THR;
            r_thresh.h1      <= DEF_HEART_THR;
            r_holds.suspect  <= DEF_SUSPECT_MS;
            r_holds.fast     <= DEF_FAST_MS;
            r_holds.slow     <= DEF_SLOW_MS;
            r_holds.cooldown <= DEF_COOLDOWN_MS;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SUSPECT_THR: r_thresh.t1      <= i_cfg.data[FIELD_W-1:0];
                CFG_ALERT_THR:   r_thresh.t2      <= i_cfg.data[FIELD_W-1:0];
                CFG_HEART_THR:   r_thresh.h1      <= i_cfg.data[FIELD_W-1:0];
                CFG_SUSPECT_MS:  r_holds.suspect  <= i_cfg.data[HOLD_W-1:0];
                CFG_FAST_MS:     r_holds.fast     <= i_cfg.data[HOLD_W-1:0];
                CFG_SLOW_MS:     r_holds.slow     <= i_cfg.data[HOLD_W-1:0];
                CFG_COOLDOWN_MS: r_holds.cooldown <= i_cfg.data[HOLD_W-1:0];
                default:         r_holds          <= r_holds;
            endcase
        end
    end

    dasf_front #(.SCORE_BITS(SCORE_BITS)) u_front (
        .i_valid        (i_req.valid),
        .o_ready        (i_req.ready),
        .i_req_type     (i_req.req_type),
        .i_fused_score  (i_req.fused_score),
        .i_heart_weight (i_req.heart_weight),
        .i_elapsed_ms   (i_req.elapsed_ms),
        .i_forced_state (i_req.forced_state),
        .i_thresh       (r_thresh),
        .o_push         (front_push),
        .o_cmd          (front_cmd),
        .i_push_ready   (queue_ready)
    );

    dasf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_push),
        .i_cmd        (front_cmd),
        .o_push_ready (queue_ready),
        .o_pop_valid  (queue_valid),
        .o_cmd        (queue_cmd),
        .i_pop        (back_pop)
    );

    dasf_back #(.SCORE_BITS(SCORE_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (queue_valid),
        .i_cmd           (queue_cmd),
        .o_pop           (back_pop),
        .i_holds         (r_holds),
        .o_valid         (o_res.valid),
        .i_ready         (o_res.ready),
        .o_session_state (o_res.session_state),
        .o_peak_score    (o_res.peak_score)
    );

endmodule

>>> rtl/core/dasf_checker.sv
// Port-level checks on the result channel of the session unit, bound to
// the top level. Depends on dasf_pkg for state codes and widths.
module dasf_checker import dasf_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [STATE_W-1:0] i_out_state,
    input logic [FIELD_W-1:0] i_out_peak
);

    logic               r_seen;
    logic [FIELD_W-1:0] r_last_peak;
    logic               out_beat;

    assign out_beat = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (out_beat) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_beat) r_last_peak <= i_out_peak;
    end

    a_reset_drops_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_state) && $stable(i_out_peak))
        else $error("stalled result changed");

    a_no_bad_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_state != ST_INVALID)
        else $error("result carries state code seven");

    // only a restart lowers the peak, and a restart always lands in baseline
    a_peak_drop_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && r_seen && (i_out_peak < r_last_peak) |-> i_out_state == ST_BASELINE)
        else $error("peak dropped outside a restart");

endmodule

bind drowsiness_alert_session_fsm_unit dasf_checker u_dasf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_state (o_res.session_state),
    .i_out_peak  (o_res.peak_score)
);

>>> tb/dasf_tb_pkg.sv
// Session tracker for the drowsiness alert session unit testbench: predicts the
// status beat of every accepted request and checks the beats that come back.
// Depends on dasf_pkg for widths, state codes, request codes and register indexes.
package dasf_tb_pkg;
    import dasf_pkg::*;

    typedef struct {
        logic [REQ_W-1:0]   kind;
        logic [FIELD_W-1:0] score;
        logic [FIELD_W-1:0] heart;
        logic [FIELD_W-1:0] ms;
        logic [STATE_W-1:0] forced;
    } t_req_beat;

    typedef struct {
        logic [STATE_W-1:0] state;
        logic [FIELD_W-1:0] peak;
    } t_status_beat;

    class session_tracker;
        t_thresh            thr;
        t_holds             holds;
        logic [STATE_W-1:0] mode;
        logic [HOLD_W-1:0]  suspect_acc;
        logic [HOLD_W-1:0]  alert_acc;
        logic [HOLD_W-1:0]  cool_acc;
        logic [FIELD_W-1:0] peak;
        t_status_beat       expected_status[$];
        int                 mismatch_count;

        function new();
            thr.t1         = DEF_SUSPECT_THR;
            thr.t2         = DEF_ALERT_THR;
            thr.h1         = DEF_HEART_THR;
            holds.suspect  = DEF_SUSPECT_MS;
            holds.fast     = DEF_FAST_MS;
            holds.slow     = DEF_SLOW_MS;
            holds.cooldown = DEF_COOLDOWN_MS;
            mode           = ST_IDLE;
            suspect_acc    = '0;
            alert_acc      = '0;
            cool_acc       = '0;
            peak           = '0;
            mismatch_count = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SUSPECT_THR: thr.t1         = val[FIELD_W-1:0];
                CFG_ALERT_THR:   thr.t2         = val[FIELD_W-1:0];
                CFG_HEART_THR:   thr.h1         = val[FIELD_W-1:0];
                CFG_SUSPECT_MS:  holds.suspect  = val[HOLD_W-1:0];
                CFG_FAST_MS:     holds.fast     = val[HOLD_W-1:0];
                CFG_SLOW_MS:     holds.slow     = val[HOLD_W-1:0];
                CFG_COOLDOWN_MS: holds.cooldown = val[HOLD_W-1:0];
                default: ;
            endcase
        endfunction

        // clamp at all ones instead of wrapping
        function logic [HOLD_W-1:0] add_ms(logic [HOLD_W-1:0] acc, logic [FIELD_W-1:0] ms);
            logic [HOLD_W:0] sum;
            sum = {1'b0, acc} + {{(HOLD_W+1-FIELD_W){1'b0}}, ms};
            return sum[HOLD_W] ? {HOLD_W{1'b1}} : sum[HOLD_W-1:0];
        endfunction

        function void step_tick(t_req_beat b);
            logic at_t1;
            logic at_t2;
            at_t1 = (b.score >= thr.t1);
            at_t2 = (b.score >= thr.t2);
            case (mode)
                ST_BASELINE: begin
                    if (at_t2) begin
                        alert_acc   = add_ms(alert_acc, b.ms);
                        suspect_acc = add_ms(suspect_acc, b.ms);
                    end else if (at_t1) begin
                        suspect_acc = add_ms(suspect_acc, b.ms);
                        alert_acc   = '0;
                    end else begin
                        suspect_acc = '0;
                        alert_acc   = '0;
                    end
                    if (suspect_acc >= holds.suspect) mode = ST_SUSPECT;
                end
                ST_SUSPECT: begin
                    if (at_t2) begin
                        alert_acc = add_ms(alert_acc, b.ms);
                        if (alert_acc >= holds.fast) mode = ST_ALERTING;
                    end else if (at_t1) begin
                        alert_acc   = '0;
                        suspect_acc = add_ms(suspect_acc, b.ms);
                        if (suspect_acc >= holds.slow && b.heart >= thr.h1) mode = ST_ALERTING;
                    end else begin
                        mode        = ST_BASELINE;
                        suspect_acc = '0;
                        alert_acc   = '0;
                    end
                end
                ST_COOLDOWN: begin
                    if (!at_t1) begin
                        cool_acc = add_ms(cool_acc, b.ms);
                        if (cool_acc >= holds.cooldown) begin
                            mode        = ST_BASELINE;
                            suspect_acc = '0;
                            alert_acc   = '0;
                            cool_acc    = '0;
                        end
                    end else begin
                        cool_acc = '0;
                        if (at_t2) mode = ST_ALERTING;
                    end
                end
                default: ;
            endcase
            if (b.score > peak) peak = b.score;
        endfunction

        function void apply_request(t_req_beat b);
            t_status_beat outcome;
            case (b.kind)
                REQ_TICK: step_tick(b);
                REQ_RESTART: begin
                    suspect_acc = '0;
                    alert_acc   = '0;
                    cool_acc    = '0;
                    peak        = '0;
                    mode        = ST_BASELINE;
                end
                REQ_FORCE: if (b.forced != ST_INVALID) mode = b.forced;
                default: ;
            endcase
            outcome.state = mode;
            outcome.peak  = peak;
            expected_status.push_back(outcome);
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatch_count++;
            $display("%0t ERROR %s: got %0d, want %0d", $time, what, got, want);
        endtask

        task check_status(logic [STATE_W-1:0] got_state, logic [FIELD_W-1:0] got_peak);
            t_status_beat want;
            if (expected_status.size() == 0) begin
                report_mismatch("status beat with nothing outstanding", got_state, 0);
                return;
            end
            want = expected_status.pop_front();
            if (got_state !== want.state) report_mismatch("session_state", got_state, want.state);
            if (got_peak !== want.peak) report_mismatch("peak_score", got_peak, want.peak);
        endtask
    endclass

endpackage

>>> tb/drowsiness_alert_session_fsm_unit_tb.sv
// Top testbench for the drowsiness alert session unit: drives requests and
// register writes, stalls the status channel, and checks every status beat.
// Depends on dasf_pkg, dasf_ifs, dasf_tb_pkg and the unit's RTL.
module drowsiness_alert_session_fsm_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dasf_pkg::*;
    import dasf_tb_pkg::*;

    localparam int LONG_STALL_CYCLES = 80;
    localparam int PHASE_ITEMS       = 95;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dasf_in_if  req_if ();
    dasf_out_if res_if ();
    dasf_cfg_if cfg_if ();

    drowsiness_alert_session_fsm_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    session_tracker tracker;
    bit             src_idle_on;
    bit             sink_idle_on;
    bit             long_stall_due;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("drowsiness_alert_session_fsm_unit: mismatch");
        $finish;
    end

    // status channel: random ready bursts, plus one long hold-off on request
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_stall_due) begin
                long_stall_due = 1'b0;
                res_if.ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge i_clk);
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            tracker.check_status(res_if.session_state, res_if.peak_score);
    end

    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [FIELD_W-1:0] score,
                            input logic [FIELD_W-1:0] heart, input logic [FIELD_W-1:0] ms,
                            input logic [STATE_W-1:0] code);
        t_req_beat b;
        b.kind   = kind;
        b.score  = score;
        b.heart  = heart;
        b.ms     = ms;
        b.forced = code;
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= kind;
        req_if.fused_score  <= score;
        req_if.heart_weight <= heart;
        req_if.elapsed_ms   <= ms;
        req_if.forced_state <= code;
        do @(posedge i_clk); while (!req_if.ready);
        tracker.apply_request(b);
    endtask

    // leaves valid high so back-to-back writes stay back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        tracker.set_reg(idx, val);
    endtask

    task automatic program_regs(input t_thresh t, input t_holds h);
        write_reg(CFG_SUSPECT_THR, CFG_DATA_W'(t.t1));
        write_reg(CFG_ALERT_THR,   CFG_DATA_W'(t.t2));
        write_reg(CFG_HEART_THR,   CFG_DATA_W'(t.h1));
        write_reg(CFG_SUSPECT_MS,  CFG_DATA_W'(h.suspect));
        write_reg(CFG_FAST_MS,     CFG_DATA_W'(h.fast));
        write_reg(CFG_SLOW_MS,     CFG_DATA_W'(h.slow));
        write_reg(CFG_COOLDOWN_MS, CFG_DATA_W'(h.cooldown));
        cfg_if.valid <= 1'b0;
    endtask

    // drop valid, drain every outstanding status beat, then let the pipe empty
    task automatic settle();
        req_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // scores clustered on both sides of the current thresholds
    function automatic logic [FIELD_W-1:0] pick_score();
        int lo1;
        int lo2;
        lo1 = tracker.thr.t1;
        lo2 = tracker.thr.t2;
        case ($urandom_range(0, 6))
            0: return '0;
            1: return '1;
            2: return (lo1 == 0) ? '0 : FIELD_W'($urandom_range(0, lo1 - 1));
            3: return FIELD_W'($urandom_range(lo1, (lo2 > lo1) ? lo2 - 1 : lo1));
            4: return FIELD_W'($urandom_range(lo2, 65535));
            5: return tracker.thr.t2;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] pick_ms();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return FIELD_W'($urandom_range(1, 600));
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int count);
        logic [REQ_W-1:0]   kind;
        logic [STATE_W-1:0] code;
        logic [FIELD_W-1:0] heart;
        int                 pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)       kind = REQ_RESTART;
            else if (pick < 24) kind = REQ_FORCE;
            else if (pick < 27) kind = REQ_RESERVED;
            else                kind = REQ_TICK;
            // cooldown is only reachable by force, so lean on it
            code  = ($urandom_range(0, 1) == 0) ? ST_COOLDOWN : STATE_W'($urandom_range(0, 7));
            heart = ($urandom_range(0, 1) == 0) ?
                    tracker.thr.h1 - FIELD_W'($urandom_range(0, 1)) : FIELD_W'($urandom);
            send_req(kind, pick_score(), heart, pick_ms(), code);
        end
    endtask

    task automatic run_directed();
        send_req(REQ_TICK,    '1, '1, '1, ST_INVALID);
        send_req(REQ_TICK,    '0, '0, '0, ST_IDLE);
        send_req(REQ_FORCE,   '0, '0, '0, ST_WARMUP);
        send_req(REQ_TICK,    16'd50000, '0, 16'd5000, ST_IDLE);
        send_req(REQ_FORCE,   '0, '0, '0, ST_CLOSING);
        send_req(REQ_TICK,    16'd50000, '0, 16'd5000, ST_IDLE);
        send_req(REQ_FORCE,   '0, '0, '0, ST_INVALID);
        send_req(REQ_RESERVED, '1, '1, '1, ST_BASELINE);
        send_req(REQ_RESTART, '1, '1, '1, ST_INVALID);
        // baseline: just under T1, then creep up to the suspect hold exactly
        send_req(REQ_TICK,    16'd32767, '0, 16'd3000, ST_IDLE);
        send_req(REQ_TICK,    16'd32768, '0, 16'd1999, ST_IDLE);
        send_req(REQ_TICK,    16'd40000, '0, 16'd1, ST_IDLE);
        // slow path with heart support exactly at threshold
        send_req(REQ_TICK,    16'd40000, 16'd32768, '1, ST_IDLE);
        send_req(REQ_FORCE,   '0, '0, '0, ST_COOLDOWN);
        send_req(REQ_TICK,    16'd1000, '0, 16'd9999, ST_IDLE);
        send_req(REQ_TICK,    '0, '0, 16'd1, ST_IDLE);
        send_req(REQ_RESTART, '0, '0, '0, ST_IDLE);
        // fast path: alert time built up in baseline carries into suspect
        send_req(REQ_TICK,    16'd45875, '0, 16'd2000, ST_IDLE);
        send_req(REQ_TICK,    16'd45875, '0, '0, ST_IDLE);
        send_req(REQ_FORCE,   '0, '0, '0, ST_SUSPECT);
        send_req(REQ_TICK,    16'd40000, 16'd32767, '1, ST_IDLE);
        send_req(REQ_TICK,    16'd100, '0, 16'd10, ST_IDLE);
        send_req(REQ_FORCE,   '0, '0, '0, ST_COOLDOWN);
        send_req(REQ_TICK,    16'd40000, '0, 16'd500, ST_IDLE);
        send_req(REQ_TICK,    16'd45875, '0, 16'd500, ST_IDLE);
        send_req(REQ_FORCE,   '0, '0, '0, ST_IDLE);
    endtask

    initial begin
        t_thresh thr;
        t_holds  holds;
        tracker = new();
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.req_type     <= REQ_TICK;
        req_if.fused_score  <= '0;
        req_if.heart_weight <= '0;
        req_if.elapsed_ms   <= '0;
        req_if.forced_state <= ST_IDLE;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= CFG_SUSPECT_THR;
        cfg_if.data         <= '0;
        src_idle_on    = 1'b1;
        sink_idle_on   = 1'b1;
        long_stall_due = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        settle();

        // ordered thresholds, short holds; the long hold-off fills the queue here
        thr.t1         = FIELD_W'($urandom_range(2000, 40000));
        thr.t2         = thr.t1 + FIELD_W'($urandom_range(0, 20000));
        thr.h1         = FIELD_W'($urandom);
        holds.suspect  = $urandom_range(0, 4000);
        holds.fast     = $urandom_range(0, 4000);
        holds.slow     = $urandom_range(0, 4000);
        holds.cooldown = $urandom_range(0, 4000);
        program_regs(thr, holds);
        long_stall_due = 1'b1;
        random_phase(PHASE_ITEMS);
        settle();

        // everything at or above threshold, every hold met at once
        thr   = '0;
        holds = '0;
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
        program_regs(thr, holds);
        random_phase(PHASE_ITEMS);
        settle();

        thr            = '1;
        holds.suspect  = $urandom_range(65535, 140000);
        holds.fast     = $urandom_range(65535, 140000);
        holds.slow     = $urandom_range(65535, 140000);
        holds.cooldown = $urandom_range(65535, 140000);
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
        program_regs(thr, holds);
        random_phase(PHASE_ITEMS);
        settle();

        // unordered thresholds
        thr.t1         = FIELD_W'($urandom);
        thr.t2         = FIELD_W'($urandom);
        thr.h1         = FIELD_W'($urandom);
        holds.suspect  = $urandom_range(0, 200000);
        holds.fast     = $urandom_range(0, 200000);
        holds.slow     = $urandom_range(0, 200000);
        holds.cooldown = $urandom_range(0, 200000);
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
        program_regs(thr, holds);
        random_phase(PHASE_ITEMS);
        settle();

        // default thresholds with short holds, no idling on either side
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        thr.t1         = DEF_SUSPECT_THR;
        thr.t2         = DEF_ALERT_THR;
        thr.h1         = DEF_HEART_THR;
        holds.suspect  = $urandom_range(0, 4000);
        holds.fast     = $urandom_range(0, 4000);
        holds.slow     = $urandom_range(0, 4000);
        holds.cooldown = $urandom_range(0, 4000);
        program_regs(thr, holds);
        send_req(REQ_RESTART, '0, '0, '0, ST_IDLE);
        random_phase(PHASE_ITEMS);
        settle();

        if (tracker.mismatch_count == 0)
            $display("drowsiness_alert_session_fsm_unit: match");
        else
            $display("drowsiness_alert_session_fsm_unit: mismatch");
        $finish;
    end

endmodule
